[sv/i2cw_pkg.sv]
// ============================================================================
// i2cw_pkg
// shared codes and transaction types for the i2c master write sequencer
// ============================================================================
package i2cw_pkg;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ST_A = 4'd1;
    localparam logic [3:0] PH_ST_B = 4'd2;
    localparam logic [3:0] PH_A_BL = 4'd3;
    localparam logic [3:0] PH_A_BH = 4'd4;
    localparam logic [3:0] PH_A_AL = 4'd5;
    localparam logic [3:0] PH_A_AH = 4'd6;
    localparam logic [3:0] PH_WAIT = 4'd7;
    localparam logic [3:0] PH_D_BL = 4'd8;
    localparam logic [3:0] PH_D_BH = 4'd9;
    localparam logic [3:0] PH_D_AL = 4'd10;
    localparam logic [3:0] PH_D_AH = 4'd11;
    localparam logic [3:0] PH_SP_A = 4'd12;
    localparam logic [3:0] PH_SP_B = 4'd13;
    localparam logic [3:0] PH_SP_C = 4'd14;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ADDR_NACK = 2'd1;
    localparam logic [1:0] ST_DATA_NACK = 2'd2;

    localparam logic [15:0] MAX_BYTES = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  target_addr;
        logic [15:0] byte_count;
        logic [7:0]  data_byte;
        logic        sda_in;
    } seq_req_t;

    typedef struct packed {
        logic [15:0] bytes_sent;
        logic [1:0]  status;
        logic        done_res;
        logic        need_byte;
        logic        busy_res;
        logic        sda;
        logic        scl;
    } seq_res_t;

endpackage

[sv/i2cw_seq.sv]
// ============================================================================
// i2cw_seq
// bus phase sequencer: state registers and single-pass next-state logic
// ============================================================================
module i2cw_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               fire,
    input  i2cw_pkg::seq_req_t req,
    output i2cw_pkg::seq_res_t res_next
);
    import i2cw_pkg::*;

    logic [15:0] tpp_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic        hold_valid_reg, hold_valid_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] acked_count_reg, acked_count_next;
    logic [15:0] divider_reg, divider_next;
    logic [1:0]  status_reg, status_next;
    logic        done_next;

    logic [15:0] period;
    logic [16:0] div_inc;
    logic [15:0] cnt_sat;
    logic        ack_ok;
    logic        cur_bit;
    logic        scl_n;
    logic        sda_n;

    assign period  = (tpp_reg == 16'd0) ? 16'd1 : tpp_reg;
    assign div_inc = {1'b0, divider_reg} + 17'd1;
    assign cnt_sat = (req.byte_count > MAX_BYTES) ? MAX_BYTES : req.byte_count;

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        hold_byte_next   = hold_byte_reg;
        hold_valid_next  = hold_valid_reg;
        remaining_next   = remaining_reg;
        acked_count_next = acked_count_reg;
        divider_next     = divider_reg;
        status_next      = status_reg;
        done_next        = 1'b0;
        ack_ok           = 1'b0;

        case (req.req_type)
            REQ_TICK:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (hold_valid_reg)
                    begin
                        shift_next      = hold_byte_reg;
                        hold_valid_next = 1'b0;
                        remaining_next  = remaining_reg - 16'd1;
                        bit_index_next  = 3'd7;
                        phase_next      = PH_D_BL;
                        divider_next    = 16'd0;
                    end
                end
                else if (phase_reg != PH_IDLE)
                begin
                    if (div_inc >= {1'b0, period})
                    begin
                        divider_next = 16'd0;
                        case (phase_reg)
                            PH_ST_A: phase_next = PH_ST_B;
                            PH_ST_B: phase_next = PH_A_BL;
                            PH_A_BL: phase_next = PH_A_BH;
                            PH_D_BL: phase_next = PH_D_BH;
                            PH_A_BH, PH_D_BH:
                            begin
                                if (bit_index_reg == 3'd0)
                                begin
                                    phase_next = (phase_reg == PH_A_BH) ? PH_A_AL : PH_D_AL;
                                end
                                else
                                begin
                                    bit_index_next = bit_index_reg - 3'd1;
                                    phase_next = (phase_reg == PH_A_BH) ? PH_A_BL : PH_D_BL;
                                end
                            end
                            PH_A_AL: phase_next = PH_A_AH;
                            PH_D_AL: phase_next = PH_D_AH;
                            PH_A_AH:
                            begin
                                if (req.sda_in)
                                begin
                                    status_next = ST_ADDR_NACK;
                                    phase_next  = PH_SP_A;
                                end
                                else
                                begin
                                    ack_ok = 1'b1;
                                end
                            end
                            PH_D_AH:
                            begin
                                if (req.sda_in)
                                begin
                                    status_next = ST_DATA_NACK;
                                    phase_next  = PH_SP_A;
                                end
                                else
                                begin
                                    acked_count_next = acked_count_reg + 16'd1;
                                    ack_ok = 1'b1;
                                end
                            end
                            PH_SP_A: phase_next = PH_SP_B;
                            PH_SP_B: phase_next = PH_SP_C;
                            PH_SP_C:
                            begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            default: ;
                        endcase
                        // after a good ack: stop, load the held byte or wait for it
                        if (ack_ok)
                        begin
                            if (remaining_reg == 16'd0)
                            begin
                                phase_next = PH_SP_A;
                            end
                            else if (hold_valid_reg)
                            begin
                                shift_next      = hold_byte_reg;
                                hold_valid_next = 1'b0;
                                remaining_next  = remaining_reg - 16'd1;
                                bit_index_next  = 3'd7;
                                phase_next      = PH_D_BL;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                            end
                        end
                    end
                    else
                    begin
                        divider_next = div_inc[15:0];
                    end
                end
            end
            REQ_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    shift_next       = {req.target_addr, 1'b0};
                    bit_index_next   = 3'd7;
                    remaining_next   = cnt_sat;
                    acked_count_next = 16'd0;
                    status_next      = ST_OK;
                    hold_valid_next  = 1'b0;
                    divider_next     = 16'd0;
                    phase_next       = PH_ST_A;
                end
            end
            REQ_DATA:
            begin
                if (phase_reg != PH_IDLE && phase_reg < PH_SP_A && !hold_valid_reg
                    && remaining_reg != 16'd0)
                begin
                    hold_byte_next  = req.data_byte;
                    hold_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // bus levels for the phase after this transaction
    assign cur_bit = shift_next[bit_index_next];

    always_comb
    begin
        scl_n = 1'b1;
        sda_n = 1'b1;
        case (phase_next)
            PH_ST_B: sda_n = 1'b0;
            PH_A_BL, PH_D_BL:
            begin
                scl_n = 1'b0;
                sda_n = cur_bit;
            end
            PH_A_BH, PH_D_BH: sda_n = cur_bit;
            PH_A_AL, PH_WAIT: scl_n = 1'b0;
            PH_SP_A:
            begin
                scl_n = 1'b0;
                sda_n = 1'b0;
            end
            PH_SP_B: sda_n = 1'b0;
            default: ;
        endcase
    end

    always_comb
    begin
        res_next.scl        = scl_n;
        res_next.sda        = sda_n;
        res_next.busy_res   = (phase_next != PH_IDLE);
        res_next.need_byte  = (phase_next != PH_IDLE) && (phase_next < PH_SP_A)
                              && !hold_valid_next && (remaining_next != 16'd0);
        res_next.done_res   = done_next;
        res_next.status     = status_next;
        res_next.bytes_sent = acked_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpp_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            tpp_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= 3'd0;
            shift_reg       <= 8'd0;
            hold_byte_reg   <= 8'd0;
            hold_valid_reg  <= 1'b0;
            remaining_reg   <= 16'd0;
            acked_count_reg <= 16'd0;
            divider_reg     <= 16'd0;
            status_reg      <= ST_OK;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            shift_reg       <= shift_next;
            hold_byte_reg   <= hold_byte_next;
            hold_valid_reg  <= hold_valid_next;
            remaining_reg   <= remaining_next;
            acked_count_reg <= acked_count_next;
            divider_reg     <= divider_next;
            status_reg      <= status_next;
        end
    end

`ifndef ASSERT_OFF
    a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req.req_type == REQ_START && phase_reg == PH_IDLE)
        |=> (phase_reg == PH_ST_A))
        else $error("start from idle did not enter start setup");

    a_done_from_stop: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |-> (phase_reg == PH_SP_C))
        else $error("done outside stop end");

    a_wait_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (remaining_reg != 16'd0))
        else $error("waiting for data with no bytes left");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(acked_count_reg) && $stable(phase_reg))
        else $error("state moved without a transaction");
`endif

endmodule

[sv/i2c_master_write_sequencer.sv]
// ============================================================================
// i2c_master_write_sequencer
// i2c master write engine, 7-bit address, one message per start
// ============================================================================
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: addr, count, data, sda_in
//  m_*      out  m_tvalid/m_tready  tdata: scl, sda, busy, need, done, status, sent
//  cfg_*    in   cfg_wr_en          cfg_wr_data: ticks_per_phase
//
//  one transaction in, one out; one transaction per clock sustained while m_tready is high
//  the sequencer state is registered on each accepted transaction, the result sits in an output register
//  a new transaction is taken when no result is pending or the result is taken in the same cycle
//  reset: sequencer idle, ticks_per_phase 1, no result pending; the result register is not reset
module i2c_master_write_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // target_addr[6:0], byte_count[22:7],
                                   // data_byte[30:23], sda_in[31]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // scl, sda, busy_res, need_byte, done_res,
                                   // status[6:5], bytes_sent[22:7], zero pad
);
    import i2cw_pkg::*;

    logic     fire;
    seq_req_t req;
    seq_res_t res_next;
    logic     m_tvalid_reg, m_tvalid_next;
    seq_res_t res_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    assign req.req_type    = s_tuser;
    assign req.target_addr = s_tdata[6:0];
    assign req.byte_count  = s_tdata[22:7];
    assign req.data_byte   = s_tdata[30:23];
    assign req.sda_in      = s_tdata[31];

    i2cw_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .req         (req),
        .res_next    (res_next)
    );

    assign m_tvalid_next = fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.bytes_sent, res_reg.status, res_reg.done_res,
                       res_reg.need_byte, res_reg.busy_res, res_reg.sda, res_reg.scl};

endmodule
